[rtl/mtg_pkg.sv]
// Shared constants, types and helper functions for the twister generator.
`default_nettype none

package mtg_pkg;

	localparam int unsigned TBL_N  = 624;
	localparam int unsigned TBL_M  = 397;
	localparam int unsigned ADDR_W = $clog2(TBL_N);

	localparam logic [31:0] MAG_XOR      = 32'h9908_b0df;
	localparam logic [31:0] LCG_MUL      = 32'd69069;
	localparam logic [31:0] INIT_MUL     = 32'd1812433253;
	localparam logic [31:0] TEMPER_B     = 32'h9d2c_5680;
	localparam logic [31:0] TEMPER_C     = 32'hefc6_0000;
	localparam logic [31:0] DEFAULT_SEED = 32'd4357;

	typedef enum logic [1:0] {
		FN_SEED_CLASSIC = 2'd0,
		FN_SEED_MULT    = 2'd1,
		FN_DRAW_RAW     = 2'd2,
		FN_DRAW_RANGED  = 2'd3
	} mtg_func_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CS_A,
		ST_CS_B,
		ST_CS_C,
		ST_CS_D,
		ST_SM_INIT,
		ST_SM_A,
		ST_SM_B,
		ST_TW_INIT,
		ST_TW_LOAD,
		ST_TW_A,
		ST_TW_B,
		ST_TW_C,
		ST_DR_RD,
		ST_DR_TEMP,
		ST_DR_OUT,
		ST_DR_MUL
	} mtg_state_t;

	// table write port
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [31:0]       data;
	} mtg_wr_t;

	function automatic logic [31:0] temper(input logic [31:0] w);
		logic [31:0] v;
		v = w;
		v = v ^ (v >> 11);
		v = v ^ ((v << 7) & TEMPER_B);
		v = v ^ ((v << 15) & TEMPER_C);
		v = v ^ (v >> 18);
		return v;
	endfunction

endpackage

`default_nettype wire

[rtl/mtg_ram.sv]
// State table: 624 x 32 memory, one write port, one registered read port.
`default_nettype none

module mtg_ram
	import mtg_pkg::*;
(
	input  wire logic              clk,
	input  wire mtg_wr_t           wr,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [31:0]       rdata
);

	logic [31:0] mem [TBL_N];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[rtl/mtg_mul.sv]
// Shared 32x32 multiplier with a registered 64-bit product.
`default_nettype none

module mtg_mul
	import mtg_pkg::*;
(
	input  wire logic        clk,
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	output logic      [63:0] prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= 64'(a) * 64'(b);
	end

endmodule

`default_nettype wire

[rtl/mersenne_twister_generator_unit.sv]
// Top level: MT19937 generator with sequencer, shared multiplier and state table.
// A draw reads and tempers a word, a ranged draw then scales it; when the table is
//   used up a twist comes first (twist walks 624 words, rewriting each in place).
// Seed classic: two LCG multiplies per word on the shared multiplier; multiplier scheme:
//   one multiply per word after word 0. A draw before any seed adds a classic seed.
// One word at a time: busy stays high until the result strobe; the receiver cannot stall.
// Reset idles the sequencer, marks the read position used up and clears the seeded flag; the table is left as is.
`default_nettype none

module mersenne_twister_generator_unit
	import mtg_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  func,
	input  wire logic [31:0] seed,
	input  wire logic [30:0] max_value,
	output logic             strobe,
	output logic      [31:0] value
);

	mtg_state_t        state_q, state_d;
	logic [ADDR_W-1:0] rp_q;        // read position, TBL_N means used up
	logic              seeded_q;
	logic              draw_pend_q; // auto-seed ahead of a draw
	logic              strobe_q;
	logic [ADDR_W-1:0] k_q;         // table walk index

	logic [31:0] s_q;     // running seed / previous word
	logic [15:0] hi_q;
	logic [31:0] cur_q;   // table[k] during twist
	logic [31:0] nxt_q;   // table[k+1] during twist
	logic [31:0] word_q;  // tempered word
	logic [31:0] value_q;
	mtg_func_t   func_q;
	logic [30:0] max_q;

	logic [31:0]       mul_a, mul_b;
	logic [63:0]       prod_q;
	mtg_wr_t           wr;
	logic [ADDR_W-1:0] raddr;
	logic [31:0]       rdata;

	logic              k_last;
	logic [ADDR_W-1:0] k_inc, k_far;
	logic [31:0]       lcg_next, sm_word, tw_y, tw_word;

	mtg_mul u_mul (
		.clk   (clk),
		.a     (mul_a),
		.b     (mul_b),
		.prod_q(prod_q)
	);

	mtg_ram u_ram (
		.clk  (clk),
		.wr   (wr),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign busy   = (state_q != ST_IDLE);
	assign strobe = strobe_q;
	assign value  = value_q;

	// index helpers for the walk, wrapping at the table end
	assign k_last = (k_q == ADDR_W'(TBL_N - 1));
	assign k_inc  = k_last ? '0 : k_q + ADDR_W'(1);
	assign k_far  = (k_q >= ADDR_W'(TBL_N - TBL_M)) ? k_q - ADDR_W'(TBL_N - TBL_M)
	                                                : k_q + ADDR_W'(TBL_M);

	assign lcg_next = prod_q[31:0] + 32'd1;
	assign sm_word  = prod_q[31:0] + 32'(k_q);

	// twist: upper bit of table[k], lower bits of table[k+1], rdata holds table[k+M]
	assign tw_y    = {cur_q[31], nxt_q[30:0]};
	assign tw_word = rdata ^ {1'b0, tw_y[31:1]} ^ (tw_y[0] ? MAG_XOR : 32'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, multiplier operands and table port
	always_comb begin
		state_d = state_q;
		mul_a   = '0;
		mul_b   = '0;
		wr      = '0;
		raddr   = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (mtg_func_t'(func))
						FN_SEED_CLASSIC: state_d = ST_CS_A;
						FN_SEED_MULT:    state_d = ST_SM_INIT;
						default: begin
							if (!seeded_q)
								state_d = ST_CS_A;
							else if (rp_q >= ADDR_W'(TBL_N))
								state_d = ST_TW_INIT;
							else
								state_d = ST_DR_RD;
						end
					endcase
				end
			end
			ST_CS_A: begin
				mul_a   = s_q;
				mul_b   = LCG_MUL;
				state_d = ST_CS_B;
			end
			ST_CS_B: begin
				wr.we   = 1'b1;
				wr.addr = k_q;
				wr.data = {hi_q, lcg_next[31:16]};
				state_d = ST_CS_C;
			end
			ST_CS_C: begin
				mul_a   = s_q;
				mul_b   = LCG_MUL;
				state_d = ST_CS_D;
			end
			ST_CS_D: begin
				if (!k_last)
					state_d = ST_CS_A;
				else if (draw_pend_q)
					state_d = ST_TW_INIT;
				else
					state_d = ST_IDLE;
			end
			ST_SM_INIT: begin
				wr.we   = 1'b1;
				wr.addr = '0;
				wr.data = s_q;
				state_d = ST_SM_A;
			end
			ST_SM_A: begin
				mul_a   = s_q ^ (s_q >> 30);
				mul_b   = INIT_MUL;
				state_d = ST_SM_B;
			end
			ST_SM_B: begin
				wr.we   = 1'b1;
				wr.addr = k_q;
				wr.data = sm_word;
				state_d = k_last ? ST_IDLE : ST_SM_A;
			end
			ST_TW_INIT: begin
				raddr   = '0;
				state_d = ST_TW_LOAD;
			end
			ST_TW_LOAD: state_d = ST_TW_A;
			ST_TW_A: begin
				raddr   = k_inc;
				state_d = ST_TW_B;
			end
			ST_TW_B: begin
				raddr   = k_far;
				state_d = ST_TW_C;
			end
			ST_TW_C: begin
				wr.we   = 1'b1;
				wr.addr = k_q;
				wr.data = tw_word;
				state_d = k_last ? ST_DR_RD : ST_TW_A;
			end
			ST_DR_RD: begin
				raddr   = rp_q;
				state_d = ST_DR_TEMP;
			end
			ST_DR_TEMP: state_d = ST_DR_OUT;
			ST_DR_OUT: begin
				if (func_q == FN_DRAW_RAW) begin
					state_d = ST_IDLE;
				end else begin
					mul_a   = word_q;
					mul_b   = {1'b0, max_q} + 32'd1;
					state_d = ST_DR_MUL;
				end
			end
			ST_DR_MUL: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q        <= ADDR_W'(TBL_N);
			seeded_q    <= 1'b0;
			draw_pend_q <= 1'b0;
			strobe_q    <= 1'b0;
			k_q         <= '0;
		end else begin
			// result shows the cycle after the last draw step
			strobe_q <= ((state_q == ST_DR_OUT) && (func_q == FN_DRAW_RAW))
			            || (state_q == ST_DR_MUL);
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						draw_pend_q <= (func == FN_DRAW_RAW) || (func == FN_DRAW_RANGED);
						k_q <= (func == FN_SEED_MULT) ? ADDR_W'(1) : '0;
					end
				end
				ST_CS_D: begin
					if (k_last) begin
						k_q      <= '0;
						rp_q     <= ADDR_W'(TBL_N);
						seeded_q <= 1'b1;
					end else begin
						k_q <= k_q + ADDR_W'(1);
					end
				end
				ST_SM_B: begin
					if (k_last) begin
						k_q      <= '0;
						rp_q     <= ADDR_W'(TBL_N);
						seeded_q <= 1'b1;
					end else begin
						k_q <= k_q + ADDR_W'(1);
					end
				end
				ST_TW_C: begin
					if (k_last) begin
						k_q  <= '0;
						rp_q <= '0;
					end else begin
						k_q <= k_q + ADDR_W'(1);
					end
				end
				ST_DR_TEMP: rp_q <= rp_q + ADDR_W'(1);
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					func_q <= mtg_func_t'(func);
					max_q  <= max_value;
					// a draw with no seed given seeds the classic way first
					if ((func == FN_SEED_CLASSIC) || (func == FN_SEED_MULT))
						s_q <= seed;
					else
						s_q <= DEFAULT_SEED;
				end
			end
			ST_CS_A:    hi_q   <= s_q[31:16];
			ST_CS_B:    s_q    <= lcg_next;
			ST_CS_D:    s_q    <= lcg_next;
			ST_SM_B:    s_q    <= sm_word;
			ST_TW_LOAD: cur_q  <= rdata;
			ST_TW_B:    nxt_q  <= rdata;
			ST_TW_C:    cur_q  <= nxt_q;
			ST_DR_TEMP: word_q <= temper(rdata);
			ST_DR_OUT:  value_q <= word_q;
			ST_DR_MUL:  value_q <= prod_q[63:32];
			default: ;
		endcase
	end

	// a result only follows a draw, and the block is free when it shows
	a_strobe_src: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> ($past(state_q) == ST_DR_OUT) || ($past(state_q) == ST_DR_MUL))
		else $error("strobe without a draw");

	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> !busy)
		else $error("strobe while busy");

	a_rp_range: assert property (@(posedge clk) disable iff (!arst_n)
		rp_q <= ADDR_W'(TBL_N))
		else $error("read position past table end");

	a_wr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wr.we |-> busy)
		else $error("table write while idle");

	a_draw_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DR_RD) |-> seeded_q && (rp_q < ADDR_W'(TBL_N)))
		else $error("draw from unseeded or used-up table");

endmodule

`default_nettype wire
